/* hdl/nggp_pkg.sv */
// Shared types, character codes and sizes for the NMEA GGA/RMC field parser.
package nggp_pkg;

  // ASCII codes the parser reacts to
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;

  // Tag matcher positions
  localparam logic [2:0] TAG_IDLE  = 3'd0;
  localparam logic [2:0] TAG_G     = 3'd1;
  localparam logic [2:0] TAG_P     = 3'd2;
  localparam logic [2:0] TAG_KIND  = 3'd3;
  localparam logic [2:0] TAG_4     = 3'd4;
  localparam logic [2:0] TAG_5     = 3'd5;
  localparam logic [2:0] TAG_DONE  = 3'd6;

  localparam logic KIND_GGA = 1'b0;
  localparam logic KIND_RMC = 1'b1;

  localparam logic [3:0] MAX_FIELDS     = 4'd14;
  localparam logic [3:0] FIELD_TIME     = 4'd1;
  localparam logic [3:0] FIELD_RMC_DATE = 4'd9;
  localparam logic [4:0] CHAR_POS_MAX   = 5'd31;

  localparam logic [26:0] WHOLE_POS_MAX = 27'd8388607;
  localparam logic [26:0] WHOLE_NEG_MAX = 27'd8388608;
  localparam logic [23:0] FRAC_MAX      = 24'd999999;

  // Token queue between classifier and field engine
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One classified word as it travels through the queue
  typedef struct packed {
    logic [7:0] ch;
    logic       is_dollar;
    logic       is_comma;
    logic       is_star;
    logic       is_dot;
    logic       is_minus;
    logic       is_digit;
    logic [3:0] digit;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hdl/nggp_byte_if.sv */
// Input channel: one received character per word.
interface nggp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

/* hdl/nggp_field_if.sv */
// Output channel: one finished field per word.
interface nggp_field_if;
  logic               valid;
  logic               ready;
  logic               sentence_kind;
  logic [3:0]         field_number;
  logic signed [23:0] whole_value;
  logic [19:0]        fraction_value;
  logic [7:0]         first_char;
  logic [6:0]         pair_high;
  logic [6:0]         pair_mid;
  logic [6:0]         pair_low;
  logic               last_field;

  modport source (output valid, output sentence_kind, output field_number,
                  output whole_value, output fraction_value, output first_char,
                  output pair_high, output pair_mid, output pair_low,
                  output last_field, input ready);
  modport sink   (input valid, input sentence_kind, input field_number,
                  input whole_value, input fraction_value, input first_char,
                  input pair_high, input pair_mid, input pair_low,
                  input last_field, output ready);
endinterface

/* hdl/nmea_gga_rmc_field_parser.sv */
// NMEA 0183 GGA/RMC field parser: classifier, token queue and field engine.
//
// Feed the NMEA byte stream one character per word on byte_ch. The block
// recognises sentences tagged $GPGGA or $GPRMC and, for every field ended by
// ',' or '*', delivers one word on field_ch: the sentence kind, the field
// number (1..14), the signed whole part and the fraction digits (both
// saturating), the field's first character, and for the time fields and the
// RMC date field (field 9) three two-digit pairs. Empty fields still produce
// a word with zero values. A '$' restarts recognition at any point; bytes
// outside a sentence, such as the checksum and line end, are ignored. The
// checksum is not checked. Throughput is one character per clock cycle: the
// classifier and the field engine each take a word every cycle, and a
// four-entry token queue between them lets either side stall on its own.
// A field word reaches field_ch through the token queue and the result
// register: its delimiter is written into the queue, and the field engine
// then takes it and loads the result register. The result register lets
// the engine carry on while a finished field waits; only when a second
// field finishes before the first is taken does the engine hold, and then
// the queue fills before byte_ch drops ready.
module nmea_gga_rmc_field_parser (
  input logic          clk,
  input logic          rst,
  nggp_byte_if.sink    byte_ch,
  nggp_field_if.source field_ch
);
  import nggp_pkg::*;

  token_t    front_token;
  token_t    back_token;
  q_status_t q_status;
  logic      push;
  logic      pop;

  // Classify and push each accepted character
  nggp_front u_front (
    .byte_ch  (byte_ch),
    .q_status (q_status),
    .push     (push),
    .token    (front_token)
  );

  // Hold tokens while the field engine is stalled
  nggp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_token),
    .pop       (pop),
    .pop_data  (back_token),
    .status    (q_status)
  );

  // Advance the tag matcher and field accumulators, emit finished fields
  nggp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .token    (back_token),
    .q_status (q_status),
    .pop      (pop),
    .field_ch (field_ch)
  );
endmodule

/* hdl/nggp_front.sv */
// Front end: accepts characters and classifies them into tokens for the queue.
module nggp_front (
  nggp_byte_if.sink          byte_ch,
  input  nggp_pkg::q_status_t q_status,
  output logic               push,
  output nggp_pkg::token_t   token
);
  import nggp_pkg::*;

  logic [7:0] c;
  logic       digit_hit;

  assign c         = byte_ch.byte_in;
  assign digit_hit = (c >= CH_ZERO) && (c <= CH_NINE);

  // Accept whenever the queue has room
  assign byte_ch.ready = !q_status.full;
  assign push          = byte_ch.valid && !q_status.full;

  always_comb begin
    token.ch        = c;
    token.is_dollar = (c == CH_DOLLAR);
    token.is_comma  = (c == CH_COMMA);
    token.is_star   = (c == CH_STAR);
    token.is_dot    = (c == CH_DOT);
    token.is_minus  = (c == CH_MINUS);
    token.is_digit  = digit_hit;
    token.digit     = digit_hit ? 4'(c - CH_ZERO) : 4'd0;
  end
endmodule

/* hdl/nggp_queue.sv */
// Short token queue between the classifier and the field engine.
module nggp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  nggp_pkg::token_t    push_data,
  input  logic                pop,
  output nggp_pkg::token_t    pop_data,
  output nggp_pkg::q_status_t status
);
  import nggp_pkg::*;

  token_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign status.full  = (count == QCW'(QDEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

/* hdl/nggp_back.sv */
// Field engine: tag matching, field accumulation and the result register.
module nggp_back (
  input  logic                clk,
  input  logic                rst,
  input  nggp_pkg::token_t    token,
  input  nggp_pkg::q_status_t q_status,
  output logic                pop,
  nggp_field_if.source        field_ch
);
  import nggp_pkg::*;

  // Remainder by ten of a value below 160
  function automatic logic [3:0] mod10(input logic [6:0] x);
    logic [7:0] r;
    r = {1'b0, x};
    if (r >= 8'd80) r = r - 8'd80;
    if (r >= 8'd40) r = r - 8'd40;
    if (r >= 8'd20) r = r - 8'd20;
    if (r >= 8'd10) r = r - 8'd10;
    return r[3:0];
  endfunction

  function automatic logic [6:0] pair_push(input logic [6:0] acc, input logic [3:0] d);
    logic [3:0] m;
    m = mod10(acc);
    return 7'(({3'd0, m} << 3) + ({3'd0, m} << 1) + {3'd0, d});
  endfunction

  logic [2:0]  tag_match_pos, tag_match_pos_next;
  logic        kind_reg, kind_reg_next;
  logic        in_sentence, in_sentence_next;
  logic [3:0]  field_count, field_count_next;
  logic [4:0]  char_pos, char_pos_next;
  logic [23:0] whole_acc, whole_acc_next;
  logic [19:0] frac_acc, frac_acc_next;
  logic        negative_flag, negative_flag_next;
  logic        after_point, after_point_next;
  logic [7:0]  first_char_reg, first_char_reg_next;
  logic [6:0]  pair_high_reg, pair_high_reg_next;
  logic [6:0]  pair_mid_reg, pair_mid_reg_next;
  logic [6:0]  pair_low_reg, pair_low_reg_next;

  logic        res_fire;
  logic        res_star;
  logic [3:0]  res_num;
  logic        res_pairs;
  logic        res_pending;
  logic        clear;
  logic        out_valid;

  // The waiting token would finish a field and so needs the result slot
  assign res_pending = in_sentence && !token.is_dollar &&
                       (token.is_comma || token.is_star) && (field_count < MAX_FIELDS);

  // Advance the engine whenever a token waits, unless it needs a result slot that is taken
  assign pop = !q_status.empty && (!out_valid || field_ch.ready || !res_pending);

  always_comb begin
    logic        tag_ok;
    logic [26:0] whole_v;
    logic [26:0] lim;
    logic [23:0] frac_v;
    tag_ok              = 1'b0;
    whole_v             = '0;
    lim                 = '0;
    frac_v              = '0;
    tag_match_pos_next  = tag_match_pos;
    kind_reg_next       = kind_reg;
    in_sentence_next    = in_sentence;
    field_count_next    = field_count;
    char_pos_next       = char_pos;
    whole_acc_next      = whole_acc;
    frac_acc_next       = frac_acc;
    negative_flag_next  = negative_flag;
    after_point_next    = after_point;
    first_char_reg_next = first_char_reg;
    pair_high_reg_next  = pair_high_reg;
    pair_mid_reg_next   = pair_mid_reg;
    pair_low_reg_next   = pair_low_reg;
    res_fire            = 1'b0;
    res_star            = token.is_star;
    res_num             = field_count + 4'd1;
    res_pairs           = (res_num == FIELD_TIME) ||
                          (kind_reg && (res_num == FIELD_RMC_DATE));
    clear               = 1'b0;

    if (pop) begin
      if (token.is_dollar) begin
        tag_match_pos_next = TAG_G;
        in_sentence_next   = 1'b0;
        field_count_next   = '0;
        clear              = 1'b1;
      end else if (!in_sentence) begin
        if (tag_match_pos == TAG_DONE) begin
          tag_match_pos_next = TAG_IDLE;
          if (token.is_comma) begin
            in_sentence_next = 1'b1;
            field_count_next = '0;
            clear            = 1'b1;
          end
        end else if (tag_match_pos != TAG_IDLE) begin
          case (tag_match_pos)
            TAG_G: tag_ok = (token.ch == CH_G);
            TAG_P: tag_ok = (token.ch == CH_P);
            TAG_KIND: begin
              if (token.ch == CH_G) begin
                kind_reg_next = KIND_GGA;
                tag_ok        = 1'b1;
              end else if (token.ch == CH_R) begin
                kind_reg_next = KIND_RMC;
                tag_ok        = 1'b1;
              end
            end
            TAG_4:   tag_ok = (token.ch == (kind_reg ? CH_M : CH_G));
            TAG_5:   tag_ok = (token.ch == (kind_reg ? CH_C : CH_A));
            default: tag_ok = 1'b0;
          endcase
          tag_match_pos_next = tag_ok ? tag_match_pos + 3'd1 : TAG_IDLE;
        end
      end else if (token.is_comma || token.is_star) begin
        if (field_count >= MAX_FIELDS) begin
          in_sentence_next = 1'b0;
        end else begin
          res_fire         = 1'b1;
          field_count_next = res_num;
          if (token.is_star) begin
            in_sentence_next = 1'b0;
          end
        end
        clear = 1'b1;
      end else begin
        if (char_pos == '0) begin
          first_char_reg_next = token.ch;
          if (token.is_minus) begin
            negative_flag_next = 1'b1;
          end
        end
        if (char_pos < 5'd2) begin
          pair_high_reg_next = pair_push(pair_high_reg, token.digit);
        end else if (char_pos < 5'd4) begin
          pair_mid_reg_next = pair_push(pair_mid_reg, token.digit);
        end else if (char_pos < 5'd6) begin
          pair_low_reg_next = pair_push(pair_low_reg, token.digit);
        end
        if (token.is_dot) begin
          after_point_next = 1'b1;
        end else if (token.is_digit) begin
          if (after_point) begin
            frac_v = ({4'd0, frac_acc} << 3) + ({4'd0, frac_acc} << 1) + 24'(token.digit);
            frac_acc_next = (frac_v > FRAC_MAX) ? FRAC_MAX[19:0] : frac_v[19:0];
          end else begin
            lim     = negative_flag ? WHOLE_NEG_MAX : WHOLE_POS_MAX;
            whole_v = ({3'd0, whole_acc} << 3) + ({3'd0, whole_acc} << 1) +
                      27'(token.digit);
            whole_acc_next = (whole_v > lim) ? lim[23:0] : whole_v[23:0];
          end
        end
        if (char_pos < CHAR_POS_MAX) begin
          char_pos_next = char_pos + 5'd1;
        end
      end
    end

    if (clear) begin
      char_pos_next       = '0;
      whole_acc_next      = '0;
      frac_acc_next       = '0;
      negative_flag_next  = 1'b0;
      after_point_next    = 1'b0;
      first_char_reg_next = '0;
      pair_high_reg_next  = '0;
      pair_mid_reg_next   = '0;
      pair_low_reg_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_match_pos  <= TAG_IDLE;
      kind_reg       <= KIND_GGA;
      in_sentence    <= 1'b0;
      field_count    <= '0;
      char_pos       <= '0;
      whole_acc      <= '0;
      frac_acc       <= '0;
      negative_flag  <= 1'b0;
      after_point    <= 1'b0;
      first_char_reg <= '0;
      pair_high_reg  <= '0;
      pair_mid_reg   <= '0;
      pair_low_reg   <= '0;
    end else begin
      tag_match_pos  <= tag_match_pos_next;
      kind_reg       <= kind_reg_next;
      in_sentence    <= in_sentence_next;
      field_count    <= field_count_next;
      char_pos       <= char_pos_next;
      whole_acc      <= whole_acc_next;
      frac_acc       <= frac_acc_next;
      negative_flag  <= negative_flag_next;
      after_point    <= after_point_next;
      first_char_reg <= first_char_reg_next;
      pair_high_reg  <= pair_high_reg_next;
      pair_mid_reg   <= pair_mid_reg_next;
      pair_low_reg   <= pair_low_reg_next;
    end
  end

  // Result register: load on a finished field, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (field_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      field_ch.sentence_kind  <= kind_reg;
      field_ch.field_number   <= res_num;
      field_ch.whole_value    <= negative_flag ? -$signed(whole_acc) : $signed(whole_acc);
      field_ch.fraction_value <= frac_acc;
      field_ch.first_char     <= first_char_reg;
      field_ch.pair_high      <= res_pairs ? pair_high_reg : 7'd0;
      field_ch.pair_mid       <= res_pairs ? pair_mid_reg : 7'd0;
      field_ch.pair_low       <= res_pairs ? pair_low_reg : 7'd0;
      field_ch.last_field     <= res_star;
    end
  end

  assign field_ch.valid = out_valid;
endmodule

/* tb/nggp_field_checker.sv */
`timescale 1ns / 100ps
// Field checker: predicts field words from accepted characters and compares them.
module nggp_field_checker
  import nggp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  nggp_byte_if  byte_ch,
  nggp_field_if field_ch,
  output int    fail_count,
  output int    outstanding
);

  typedef struct packed {
    logic               kind;
    logic [3:0]         num;
    logic signed [23:0] whole;
    logic [19:0]        frac;
    logic [7:0]         first;
    logic [6:0]         hi;
    logic [6:0]         mid;
    logic [6:0]         lo;
    logic               last;
  } field_word_t;

  field_word_t expected_fields[$];
  int          mismatches = 0;
  int          waiting    = 0;

  // Sentence and field state of the parser as predicted
  logic [2:0]  tag_pos       = TAG_IDLE;
  logic        kind          = KIND_GGA;
  logic        in_sentence   = 1'b0;
  logic [3:0]  fields_done   = '0;
  logic [4:0]  char_pos      = '0;
  logic [23:0] whole_mag     = '0;
  logic [19:0] frac          = '0;
  logic        negative      = 1'b0;
  logic        after_point   = 1'b0;
  logic [7:0]  first         = '0;
  logic [6:0]  pair_hi       = '0;
  logic [6:0]  pair_mid      = '0;
  logic [6:0]  pair_lo       = '0;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  task automatic clear_field();
    char_pos    = '0;
    whole_mag   = '0;
    frac        = '0;
    negative    = 1'b0;
    after_point = 1'b0;
    first       = '0;
    pair_hi     = '0;
    pair_mid    = '0;
    pair_lo     = '0;
  endtask

  function automatic logic [6:0] push_pair(input logic [6:0] acc, input logic [3:0] d);
    return 7'((32'(acc) % 10) * 10 + 32'(d));
  endfunction

  task automatic parse_byte(input logic [7:0] c);
    field_word_t w;
    logic [3:0]  num;
    logic        show_pairs;
    logic        is_digit;
    logic        ok;
    logic [3:0]  d;
    int unsigned v;
    int unsigned lim;
    if (c == CH_DOLLAR) begin
      tag_pos     = TAG_G;
      in_sentence = 1'b0;
      fields_done = '0;
      clear_field();
      return;
    end
    if (!in_sentence) begin
      if (tag_pos == TAG_IDLE) return;
      if (tag_pos == TAG_DONE) begin
        tag_pos = TAG_IDLE;
        if (c == CH_COMMA) begin
          in_sentence = 1'b1;
          fields_done = '0;
          clear_field();
        end
        return;
      end
      case (tag_pos)
        TAG_G:    ok = (c == CH_G);
        TAG_P:    ok = (c == CH_P);
        TAG_KIND: begin
          ok = (c == CH_G) || (c == CH_R);
          if (ok) kind = (c == CH_R) ? KIND_RMC : KIND_GGA;
        end
        TAG_4:    ok = (c == ((kind == KIND_RMC) ? CH_M : CH_G));
        TAG_5:    ok = (c == ((kind == KIND_RMC) ? CH_C : CH_A));
        default:  ok = 1'b0;
      endcase
      tag_pos = ok ? tag_pos + 3'd1 : TAG_IDLE;
      return;
    end
    if (c == CH_COMMA || c == CH_STAR) begin
      if (fields_done >= MAX_FIELDS) begin
        in_sentence = 1'b0;
        clear_field();
        return;
      end
      num        = fields_done + 4'd1;
      show_pairs = (num == FIELD_TIME) || (kind == KIND_RMC && num == FIELD_RMC_DATE);
      w.kind  = kind;
      w.num   = num;
      w.whole = negative ? 24'd0 - whole_mag : whole_mag;
      w.frac  = frac;
      w.first = first;
      w.hi    = show_pairs ? pair_hi  : 7'd0;
      w.mid   = show_pairs ? pair_mid : 7'd0;
      w.lo    = show_pairs ? pair_lo  : 7'd0;
      w.last  = (c == CH_STAR);
      expected_fields.push_back(w);
      fields_done = num;
      if (c == CH_STAR) in_sentence = 1'b0;
      clear_field();
      return;
    end
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d        = is_digit ? 4'(c - CH_ZERO) : 4'd0;
    if (char_pos == 0) begin
      first = c;
      if (c == CH_MINUS) negative = 1'b1;
    end
    if (char_pos < 2)      pair_hi  = push_pair(pair_hi, d);
    else if (char_pos < 4) pair_mid = push_pair(pair_mid, d);
    else if (char_pos < 6) pair_lo  = push_pair(pair_lo, d);
    if (c == CH_DOT) begin
      after_point = 1'b1;
    end else if (is_digit) begin
      if (after_point) begin
        v    = 32'(frac) * 10 + 32'(d);
        frac = (v > FRAC_MAX) ? FRAC_MAX[19:0] : v[19:0];
      end else begin
        lim       = negative ? 32'(WHOLE_NEG_MAX) : 32'(WHOLE_POS_MAX);
        v         = 32'(whole_mag) * 10 + 32'(d);
        whole_mag = (v > lim) ? lim[23:0] : v[23:0];
      end
    end
    if (char_pos < CHAR_POS_MAX) char_pos = char_pos + 5'd1;
  endtask

  task automatic check_value(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t  %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    field_word_t seen;
    field_word_t want;
    if (rst) begin
      tag_pos     = TAG_IDLE;
      kind        = KIND_GGA;
      in_sentence = 1'b0;
      fields_done = '0;
      clear_field();
      expected_fields.delete();
    end else begin
      if (field_ch.valid && field_ch.ready) begin
        seen = '{field_ch.sentence_kind, field_ch.field_number, field_ch.whole_value,
                 field_ch.fraction_value, field_ch.first_char, field_ch.pair_high,
                 field_ch.pair_mid, field_ch.pair_low, field_ch.last_field};
        if (expected_fields.size() == 0) begin
          mismatches++;
          $display("%0t  field word with none expected: expected nothing, actual %p",
                   $time, seen);
        end else begin
          want = expected_fields.pop_front();
          check_value("sentence_kind",  want.kind,  seen.kind);
          check_value("field_number",   want.num,   seen.num);
          check_value("whole_value",    want.whole, seen.whole);
          check_value("fraction_value", want.frac,  seen.frac);
          check_value("first_char",     want.first, seen.first);
          check_value("pair_high",      want.hi,    seen.hi);
          check_value("pair_mid",       want.mid,   seen.mid);
          check_value("pair_low",       want.lo,    seen.lo);
          check_value("last_field",     want.last,  seen.last);
        end
      end
      if (byte_ch.valid && byte_ch.ready) parse_byte(byte_ch.byte_in);
    end
    waiting <= expected_fields.size();
  end

endmodule

/* tb/nmea_gga_rmc_field_parser_tb.sv */
`timescale 1ns / 100ps
// Top of the field parser testbench: character stream, flow control and verdict.
module nmea_gga_rmc_field_parser_tb;
  import nggp_pkg::*;

  // Cycle at which the field side starts its long hold-off, and its length:
  // long enough to fill the result register and the token queue so that
  // byte_ch drops ready while characters are still on offer.
  localparam int HOLD_AT    = 800;
  localparam int HOLD_LEN   = 400;
  // Watchdog, far above the slowest legal run of this stream
  localparam int LIMIT      = 400000;
  // Characters in random sentences to aim for
  localparam int GOOD_BYTES = 1500;
  // Cycles to keep watching once nothing is expected; a field word trails
  // its delimiter only by the queue and result register, so this is ample.
  localparam int TAIL       = 16;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   fail_count;
  int   outstanding;
  int   rx_calm = 0;
  int   rx_stall = 0;

  logic [7:0] stream[$];

  nggp_byte_if  byte_ch();
  nggp_field_if field_ch();

  nmea_gga_rmc_field_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .field_ch (field_ch)
  );

  nggp_field_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .byte_ch     (byte_ch),
    .field_ch    (field_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count cycles and end a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Idle pattern shared by both sides: mostly back to back, some short gaps,
  // a few long ones, and now and then a calm stretch with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) stream.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // One field's content: time or date shape where the pairs matter, signed
  // decimals, single indicator letters, empty fields and runs of junk,
  // a few of them long enough to run the position counter to its limit.
  task automatic add_field(input int idx, input logic kind);
    string      letters;
    int         r;
    int         n;
    logic [7:0] c;
    letters = "AVNSEWM";
    r = $urandom_range(0, 99);
    if ((idx == FIELD_TIME || (kind == KIND_RMC && idx == FIELD_RMC_DATE)) && r < 60) begin
      add_digits(6);
      if ($urandom_range(0, 1)) begin
        stream.push_back(CH_DOT);
        add_digits($urandom_range(0, 3));
      end
    end else if (r < 15) begin
      // leave the field empty
    end else if (r < 65) begin
      if ($urandom_range(0, 3) == 0) stream.push_back(CH_MINUS);
      add_digits($urandom_range(0, 9));
      if ($urandom_range(0, 1)) begin
        stream.push_back(CH_DOT);
        add_digits($urandom_range(0, 8));
      end
    end else if (r < 80) begin
      stream.push_back(letters[$urandom_range(0, 6)]);
    end else begin
      n = (r < 97) ? $urandom_range(1, 8) : $urandom_range(28, 40);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255));
        while (c == CH_DOLLAR || c == CH_COMMA || c == CH_STAR);
        stream.push_back(c);
      end
    end
  endtask

  // A sentence with random content; now and then it runs past the field
  // limit, loses its '*' or is cut short by the next '$'.
  task automatic add_sentence();
    logic kind;
    int   n;
    int   r;
    kind = 1'($urandom_range(0, 1));
    push_text((kind == KIND_RMC) ? "$GPRMC," : "$GPGGA,");
    r = $urandom_range(0, 99);
    n = (r < 85) ? $urandom_range(1, 14) : $urandom_range(15, 17);
    for (int i = 1; i <= n; i++) begin
      add_field(i, kind);
      if (i < n) stream.push_back(CH_COMMA);
    end
    r = $urandom_range(0, 99);
    if (r < 85) push_text("*5A\r\n");
    else if (r < 93) stream.push_back(CH_COMMA);
  endtask

  task automatic build_stream();
    int    r;
    int    good;
    int    start_len;
    string tag_letters;
    tag_letters = "GRPAMCX";
    // Directed opening: stray text outside a sentence, a GGA time with its
    // pairs, a negative whole part past saturation, an empty field, an
    // indicator letter and the byte extremes inside a field.
    push_text("xyz$GPGGA,123519.25,-8388609.1,,A,");
    stream.push_back(8'hFF);
    stream.push_back(8'h00);
    push_text("*47\r\n");
    // RMC: second point ignored, both values saturating, date in field 9,
    // then one delimiter too many ends the sentence with no word.
    push_text("$GPRMC,1.2.3,99999999,.1234567,,,,,,311299,,,,,,,X*");
    // Tag mismatch, tag without its comma, and a '$' dropping a sentence.
    push_text("$GPGAA,1*$GPRMCX,2*$GPGGA,12$GPGGA,-7*");

    good = 0;
    while (good < GOOD_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        start_len = stream.size();
        add_sentence();
        good += stream.size() - start_len;
      end else if (r < 90) begin
        if ($urandom_range(0, 1)) begin
          push_text("$GP");
          repeat ($urandom_range(1, 3)) stream.push_back(tag_letters[$urandom_range(0, 6)]);
        end else begin
          push_text($urandom_range(0, 1) ? "$GPGGA" : "$GPRMC");
          stream.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) stream.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Field side: random stalls, plus one long hold-off counted here
  initial begin
    field_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycles == HOLD_AT) rx_stall = HOLD_LEN;
      if (rx_stall > 0) begin
        field_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        field_ch.ready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  // Character side: reset, then offer the stream word by word
  initial begin : stimulus
    int tx_calm;
    int gap;
    tx_calm         = 0;
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = '0;
    build_stream();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stream.size() != 0) begin
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // Hold the word until it is taken, then move on at the next falling edge
      byte_ch.valid   <= 1'b1;
      byte_ch.byte_in <= stream.pop_front();
      do @(posedge clk); while (!byte_ch.ready);
      @(negedge clk);
    end
    byte_ch.valid <= 1'b0;

    // Drain every expected field word, then watch a little longer for strays
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
